// ===== rtl/core/pcm_channel_downmix_average_top_assert.svh =====
// Assertion macros for the downmix averager checker.
`ifndef PCM_CHANNEL_DOWNMIX_AVERAGE_TOP_ASSERT_SVH
`define PCM_CHANNEL_DOWNMIX_AVERAGE_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PCDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PCDA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/pcda_pkg.sv =====
// Shared types, codes and helper functions of the downmix averager.
package pcda_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FMT_W    = 2;
  localparam int COUNT_W  = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [FMT_W-1:0] FMT_8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_24 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_32 = 2'd3;

  localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

  localparam logic [0:0] REG_FORMAT = 1'b0;
  localparam logic [0:0] REG_COUNT  = 1'b1;

  typedef struct packed {
    logic acc;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  function automatic logic signed [SAMPLE_W-1:0] widen(
    input logic [FMT_W-1:0]    fmt,
    input logic [SAMPLE_W-1:0] raw
  );
    logic signed [SAMPLE_W-1:0] res;
    case (fmt)
      FMT_8:   res = SAMPLE_W'(signed'(raw[7:0]));
      FMT_16:  res = SAMPLE_W'(signed'(raw[15:0]));
      FMT_24:  res = signed'({raw[23:0], 8'h00});
      default: res = signed'(raw);
    endcase
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pack_out(
    input logic [FMT_W-1:0]    fmt,
    input logic [SAMPLE_W-1:0] avg
  );
    logic [SAMPLE_W-1:0] res;
    case (fmt)
      FMT_8:   res = {24'h000000, avg[7:0]};
      FMT_16:  res = {16'h0000, avg[15:0]};
      FMT_24:  res = {8'h00, avg[31:8]};
      default: res = avg;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/pcm_channel_downmix_average_top.sv =====
// Top level of the multichannel PCM to mono downmix averager.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   in_sample[31:0]
//   out      source     out_valid/out_stall out_mono_sample[31:0]
//   cfg      APB write  psel/penable/pwrite paddr[2:0], pwdata[31:0]
//
// A sample that does not end a frame is added to the running sum; the next may follow at once.
// A frame-ending sample starts the bit-serial divider over the SUM_W-bit sum (SUM_W = 35
// at MAX_CHANNELS = 8); input stalls through the divide steps and the result register load.
// The result register holds while out_stall is high; input is still taken then
// until the next frame end finds it full, which extends the load step.
// Reset (rst_n low, synchronous) clears the sum, position and registers to defaults.
module pcm_channel_downmix_average_top #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pcda_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcda_pkg::SAMPLE_W-1:0]       out_mono_sample,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pcda_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [pcda_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [pcda_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CW      = pcda_pkg::COUNT_W;
  localparam int CNT_MAX = (1 << CW) - 1;
  localparam int EFF_MAX = (MAX_CHANNELS < CNT_MAX) ? MAX_CHANNELS : CNT_MAX;
  localparam int SUM_W   = pcda_pkg::SAMPLE_W + $clog2(EFF_MAX);
  localparam int POS_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

  logic [pcda_pkg::FMT_W-1:0] fmt_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              eff_count;
  logic                       cfg_wr;
  pcda_pkg::cmd_t             cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= pcda_pkg::FMT_RESET;
      count_r <= pcda_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        pcda_pkg::REG_FORMAT: fmt_r   <= cfg_pwdata[pcda_pkg::FMT_W-1:0];
        pcda_pkg::REG_COUNT:  count_r <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      pcda_pkg::REG_FORMAT: cfg_prdata = pcda_pkg::PDATA_W'(fmt_r);
      pcda_pkg::REG_COUNT:  cfg_prdata = pcda_pkg::PDATA_W'(count_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // clamp the channel count to 1..EFF_MAX
  always_comb begin
    if (count_r == '0) begin
      eff_count = CW'(1);
    end else if (count_r > CW'(EFF_MAX)) begin
      eff_count = CW'(EFF_MAX);
    end else begin
      eff_count = count_r;
    end
  end

  pcda_ctrl #(
    .SUM_W (SUM_W),
    .POS_W (POS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .eff_count (eff_count),
    .cmd       (cmd)
  );

  pcda_dp #(
    .SUM_W (SUM_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .fmt             (fmt_r),
    .eff_count       (eff_count),
    .in_sample       (in_sample),
    .out_mono_sample (out_mono_sample)
  );

endmodule

// ===== rtl/core/pcda_ctrl.sv =====
// Controller: frame position, divide sequencing and result handshake.
module pcda_ctrl #(
  parameter int SUM_W = 35,
  parameter int POS_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pcda_pkg::COUNT_W-1:0]  eff_count,
  output pcda_pkg::cmd_t                cmd
);

  localparam int CMP_W  = pcda_pkg::COUNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CMP_W-1:0]  pos_inc;
  logic              last;
  logic              accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign pos_inc   = CMP_W'(pos_r) + CMP_W'(1);
  assign last      = (pos_inc >= CMP_W'(eff_count));

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.acc = 1'b1;
          if (last) begin
            cmd.start = 1'b1;
            pos_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end else begin
            pos_nxt = POS_W'(pos_inc);
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/pcda_dp.sv =====
// Datapath: running sum, serial restoring divider and result register.
module pcda_dp #(
  parameter int SUM_W = 35
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcda_pkg::cmd_t                 cmd,
  input  logic [pcda_pkg::FMT_W-1:0]     fmt,
  input  logic [pcda_pkg::COUNT_W-1:0]   eff_count,
  input  logic [pcda_pkg::SAMPLE_W-1:0]  in_sample,
  output logic [pcda_pkg::SAMPLE_W-1:0]  out_mono_sample
);

  localparam int CW = pcda_pkg::COUNT_W;
  localparam int SW = pcda_pkg::SAMPLE_W;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] total;
  logic [SUM_W-1:0]        total_mag;
  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           div_r;
  logic                    neg_r;
  logic [CW:0]             shifted;
  logic [CW:0]             diff;
  logic                    ge;
  logic [SUM_W-1:0]        quo_signed;
  logic [SW-1:0]           out_r;

  assign total     = sum_r + SUM_W'(pcda_pkg::widen(fmt, in_sample));
  assign total_mag = total[SUM_W-1] ? unsigned'(-total) : unsigned'(total);

  assign shifted    = {rem_r, quo_r[SUM_W-1]};
  assign ge         = (shifted >= {1'b0, div_r});
  assign diff       = shifted - {1'b0, div_r};
  assign rem_nxt    = ge ? diff[CW-1:0] : shifted[CW-1:0];
  assign quo_nxt    = {quo_r[SUM_W-2:0], ge};
  assign quo_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.acc) begin
      sum_nxt = cmd.start ? '0 : total;
    end
  end

  // hold the frame sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo_r <= total_mag;
      neg_r <= total[SUM_W-1];
      rem_r <= '0;
      div_r <= eff_count;
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.load) begin
      out_r <= pcda_pkg::pack_out(fmt, quo_signed[SW-1:0]);
    end
  end

  assign out_mono_sample = out_r;

endmodule

// ===== rtl/core/pcda_checker.sv =====
// Port-level checker for the downmix averager and its bind.
`include "pcm_channel_downmix_average_top_assert.svh"

module pcda_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [pcda_pkg::SAMPLE_W-1:0]      out_mono_sample
);

  `PCDA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_mono_sample), "out beat changed while stalled")
  `PCDA_NEVER(a_out_from_div, $rose(out_valid) && !$past(in_stall), "result beat without a divide")
  `PCDA_ASSERT(a_div_multi, $rose(in_stall) |=> in_stall, "divide finished in one cycle")
  `PCDA_ASSERT(a_div_result, $fell(in_stall) |-> out_valid, "divide ended without a result beat")

endmodule

bind pcm_channel_downmix_average_top pcda_checker u_pcda_checker (.*);
